// ===== rtl/greedy_gated_assignment_macros.svh =====
// Assertion macros shared by the greedy gated assignment RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef GREEDY_GATED_ASSIGNMENT_MACROS_SVH
`define GREEDY_GATED_ASSIGNMENT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset
`define GGA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, checked outside reset
`define GGA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define GGA_ASSERT_IMPL(label, ante, cons)
`define GGA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/gga_pkg.sv =====
// Shared constants and types for the greedy gated assignment block.
// No dependencies; imported by every module of the block.
package gga_pkg;

    // Capacities
    localparam int MAX_COLS    = 64;
    localparam int MAX_ROWS    = 256;

    // Field widths
    localparam int COST_W      = 32;
    localparam int SUM_W       = 48;
    localparam int COL_FIELD_W = 6;
    localparam int ROW_FIELD_W = 8;

    // Column capacity limited by the column field width
    localparam int COL_LIMIT   = 2 ** COL_FIELD_W;
    localparam int COL_CAP     = (MAX_COLS < COL_LIMIT) ? MAX_COLS : COL_LIMIT;
    localparam int COL_IDX_W   = (COL_CAP > 1) ? $clog2(COL_CAP) : 1;

    // Column counter saturates, never wraps onto a valid column
    localparam int CNT_W       = 7;

    // Row counter
    localparam int ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ROW_EXT_W   = (ROW_W > ROW_FIELD_W) ? ROW_W : ROW_FIELD_W;

    // Stream widths
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 64;
    localparam int OUT_USED_W  = ROW_FIELD_W + 1 + COL_FIELD_W + SUM_W;

    // One input beat
    typedef struct packed {
        logic signed [COST_W-1:0] cost;
        logic                     row_end;
        logic                     matrix_end;
    } gga_item_t;

    // One result beat
    typedef struct packed {
        logic [ROW_FIELD_W-1:0]  row_index;
        logic                    assigned;
        logic [COL_FIELD_W-1:0]  assigned_column;
        logic signed [SUM_W-1:0] total_cost;
        logic                    last;
    } gga_result_t;

endpackage

// ===== rtl/gga_core.sv =====
// Per-beat assignment logic: gate test, claimed-column bitmap, best tracking,
// saturating cost sum and row bookkeeping. Depends on gga_pkg and the macros header.
`include "greedy_gated_assignment_macros.svh"

module gga_core
    import gga_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     fire,
    input  gga_item_t                item,
    input  logic signed [COST_W-1:0] max_cost,
    output logic                     res_valid,
    output gga_result_t              res
);

    logic [COL_CAP-1:0]       claimed_reg, claimed_next;
    logic signed [COST_W-1:0] best_cost_reg, best_cost_next;
    logic [COL_FIELD_W-1:0]   best_col_reg, best_col_next;
    logic                     found_reg, found_next;
    logic [CNT_W-1:0]         col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0]         row_cnt_reg, row_cnt_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;

    logic                     row_done;
    logic                     in_range;
    logic                     take;
    logic signed [SUM_W:0]    sum_wide;
    logic signed [SUM_W-1:0]  sum_sat;
    logic [ROW_EXT_W-1:0]     row_ext;

    assign row_done = item.row_end | item.matrix_end;
    assign in_range = col_cnt_reg < CNT_W'(COL_CAP);

    // Candidate test: inside capacity, at or under the gate, column free, strictly better
    always_comb
    begin
        take = in_range && (item.cost <= max_cost)
            && !claimed_reg[col_cnt_reg[COL_IDX_W-1:0]]
            && (!found_reg || (item.cost < best_cost_reg));
    end

    // Saturating add of the row's best cost
    always_comb
    begin
        sum_wide = $signed({sum_reg[SUM_W-1], sum_reg}) + (SUM_W+1)'(best_cost_next);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    // Next-state logic
    always_comb
    begin
        best_cost_next = take ? item.cost : best_cost_reg;
        best_col_next  = take ? COL_FIELD_W'(col_cnt_reg) : best_col_reg;
        found_next     = found_reg | take;
        claimed_next   = claimed_reg;
        sum_next       = sum_reg;
        row_cnt_next   = row_cnt_reg;
        col_cnt_next   = (col_cnt_reg == {CNT_W{1'b1}}) ? col_cnt_reg
                                                          : col_cnt_reg + 1'b1;
        if (row_done)
        begin
            if (found_next)
            begin
                sum_next = sum_sat;
                claimed_next[best_col_next[COL_IDX_W-1:0]] = 1'b1;
            end
            row_cnt_next = (row_cnt_reg == ROW_W'(MAX_ROWS - 1)) ? '0
                                                                 : row_cnt_reg + 1'b1;
            col_cnt_next = '0;
            if (item.matrix_end)
            begin
                claimed_next = '0;
                sum_next     = '0;
                row_cnt_next = '0;
            end
        end
    end

    // Result for the row that ends with this beat
    assign row_ext             = ROW_EXT_W'(row_cnt_reg);
    assign res_valid           = fire & row_done;
    assign res.row_index       = row_ext[ROW_FIELD_W-1:0];
    assign res.assigned        = found_next;
    assign res.assigned_column = found_next ? best_col_next : '0;
    assign res.total_cost      = found_next ? sum_sat : sum_reg;
    assign res.last            = item.matrix_end;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            claimed_reg   <= '0;
            best_cost_reg <= '0;
            best_col_reg  <= '0;
            found_reg     <= 1'b0;
            col_cnt_reg   <= '0;
            row_cnt_reg   <= '0;
            sum_reg       <= '0;
        end
        else if (fire)
        begin
            claimed_reg   <= claimed_next;
            best_cost_reg <= row_done ? '0 : best_cost_next;
            best_col_reg  <= row_done ? '0 : best_col_next;
            found_reg     <= row_done ? 1'b0 : found_next;
            col_cnt_reg   <= col_cnt_next;
            row_cnt_reg   <= row_cnt_next;
            sum_reg       <= sum_next;
        end
    end

    // Checks
    `GGA_ASSERT_NEXT(a_matrix_clears, fire && item.matrix_end, claimed_reg == '0 && sum_reg == '0)
    `GGA_ASSERT_NEXT(a_row_clears, fire && row_done, col_cnt_reg == '0 && !found_reg)
    `GGA_ASSERT_IMPL(a_best_in_range, found_reg, best_col_reg < COL_FIELD_W'(COL_CAP - 1) || best_col_reg == COL_FIELD_W'(COL_CAP - 1))

endmodule

// ===== rtl/gga_out_buf.sv =====
// Result register with a skid entry so the core keeps running while the
// receiver stalls. Depends on gga_pkg and the macros header.
`include "greedy_gated_assignment_macros.svh"

module gga_out_buf
    import gga_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  gga_result_t push_data,
    output logic        full,
    output logic        out_valid,
    input  logic        out_ready,
    output gga_result_t out_data
);

    logic        main_valid_reg, main_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    gga_result_t main_reg;
    gga_result_t skid_reg;
    logic        main_free;

    assign main_free = !main_valid_reg || out_ready;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // Occupancy
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (main_free)
        begin
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
            end
            else if (push)
            begin
                main_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

    // Checks
    `GGA_ASSERT_IMPL(a_skid_behind_main, skid_valid_reg, main_valid_reg)
    `GGA_ASSERT_IMPL(a_no_overflow, push, !skid_valid_reg)
    `GGA_ASSERT_NEXT(a_stall_fills_skid, push && main_valid_reg && !out_ready, skid_valid_reg && main_valid_reg)

endmodule

// ===== rtl/greedy_gated_assignment.sv =====
// Top level of the greedy gated assignment block: input register, gate
// register, assignment core and result buffer. Depends on gga_pkg, gga_core, gga_out_buf.
//
// Usage:
//   s_* carries the cost matrix in row-major order, one signed Q16.16 cost
//   per beat; s_tlast marks the last column of a row, s_tuser marks the last
//   entry of the matrix (which also ends its row).
//   m_* delivers one beat per row: row index, assigned flag, column and the
//   saturating running cost total; m_tlast marks the final row of the matrix.
//   cfg_* writes the gate max_cost; always ready, write only while idle.
//   Path: a row's last beat passes the input register, then the result
//   register (or the skid entry first), before it shows on m_tvalid.
//   Throughput: one cost beat per cycle while the skid entry has room, set by
//   the per-beat compare and bitmap update in the core.
//   Reset: claimed columns, running total and row counter clear; the gate
//   returns to 0x7FFFFFFF.
//   Receiver stall: a skid entry holds one extra result; once it is full and
//   the input register holds a beat, s_tready drops until m_tready frees the
//   result register.
module greedy_gated_assignment
    import gga_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] cost
    input  logic                   s_tlast,   // row_end
    input  logic                   s_tuser,   // matrix_end
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] row_index, [8] assigned,
                                              // [14:9] assigned_column,
                                              // [62:15] total_cost, [63] zero
    output logic                   m_tlast,   // last
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [COST_W-1:0]      cfg_data   // max_cost
);

    logic                     in_valid_reg, in_valid_next;
    gga_item_t                in_item_reg;
    logic signed [COST_W-1:0] max_cost_reg;
    logic                     in_accept;
    logic                     fire;
    logic                     buf_full;
    logic                     res_valid;
    gga_result_t              res;
    gga_result_t              out_res;

    // Gate register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_cost_reg <= {1'b0, {(COST_W-1){1'b1}}};
        end
        else if (cfg_valid)
        begin
            max_cost_reg <= $signed(cfg_data);
        end
    end

    // Input register
    assign fire      = in_valid_reg && !buf_full;
    assign s_tready  = !in_valid_reg || !buf_full;
    assign in_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_item_reg.cost       <= $signed(s_tdata[COST_W-1:0]);
            in_item_reg.row_end    <= s_tlast;
            in_item_reg.matrix_end <= s_tuser;
        end
    end

    // Assignment core
    gga_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (in_item_reg),
        .max_cost  (max_cost_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register and skid entry
    gga_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // Output packing
    assign m_tdata = {{(OUT_TDATA_W-OUT_USED_W){1'b0}}, out_res.total_cost,
                      out_res.assigned_column, out_res.assigned, out_res.row_index};
    assign m_tlast = out_res.last;

endmodule

// ===== test/gga_assignment_checker.sv =====
// Checker for the greedy gated assignment block: watches the cost, result and gate channels,
// predicts each row's pick and compares the result beats field by field.
// Depends on gga_pkg for widths, capacities and the result struct.
`timescale 1ns / 1ps

module gga_assignment_checker
    import gga_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] cost
    input  logic                   s_tlast,   // row_end
    input  logic                   s_tuser,   // matrix_end
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] row_index, [8] assigned,
                                              // [14:9] assigned_column,
                                              // [62:15] total_cost, [63] zero
    input  logic                   m_tlast,   // last
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [COST_W-1:0]      cfg_data,  // max_cost
    output int                     fail_count,
    output int                     rows_pending
);

    localparam logic signed [63:0] SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] SUM_LO = -SUM_HI - 64'sd1;
    localparam logic [CNT_W-1:0]   CNT_TOP = '1;

    // Predicted block state
    logic [63:0]              claimed;
    logic signed [COST_W-1:0] best_cost;
    logic [COL_FIELD_W-1:0]   best_col;
    logic                     found;
    logic [CNT_W-1:0]         col_count;
    logic [ROW_FIELD_W-1:0]   row_count;
    logic signed [SUM_W-1:0]  running_sum;
    logic signed [COST_W-1:0] gate;

    gga_result_t expected_rows[$];
    int          mismatches = 0;

    task automatic clear_row_pick();
        best_cost = '0;
        best_col  = '0;
        found     = 1'b0;
        col_count = '0;
    endtask

    // One cost beat: update the running best, and at a row end queue the row's result
    task automatic predict_row_pick(input logic signed [COST_W-1:0] cost,
                                    input logic row_end, input logic matrix_end);
        logic signed [63:0] sum_next;
        gga_result_t        row_res;
        if (col_count < COL_CAP && cost <= gate && !claimed[col_count[COL_IDX_W-1:0]]
            && (!found || cost < best_cost))
        begin
            best_cost = cost;
            best_col  = col_count[COL_IDX_W-1:0];
            found     = 1'b1;
        end
        // counter saturates so it never wraps back onto a valid column
        if (col_count < CNT_TOP)
            col_count = col_count + 1'b1;

        if (row_end || matrix_end)
        begin
            if (found)
            begin
                sum_next = running_sum + best_cost;
                if (sum_next > SUM_HI)
                    sum_next = SUM_HI;
                if (sum_next < SUM_LO)
                    sum_next = SUM_LO;
                running_sum       = sum_next[SUM_W-1:0];
                claimed[best_col] = 1'b1;
            end
            row_res.row_index       = row_count;
            row_res.assigned        = found;
            row_res.assigned_column = found ? best_col : '0;
            row_res.total_cost      = running_sum;
            row_res.last            = matrix_end;
            expected_rows.push_back(row_res);

            row_count = ROW_FIELD_W'((int'(row_count) + 1) % MAX_ROWS);
            clear_row_pick();
            // a matrix end starts a fresh matrix
            if (matrix_end)
            begin
                claimed     = '0;
                running_sum = '0;
                row_count   = '0;
            end
        end
    endtask

    // One result beat against the oldest queued row
    task automatic check_row_beat();
        gga_result_t want;
        logic        bad;
        if (expected_rows.size() == 0)
        begin
            if (mismatches < 10)
                $display("%t: result beat with no row pending: tdata=%h tlast=%b",
                         $realtime, m_tdata, m_tlast);
            mismatches++;
        end
        else
        begin
            want = expected_rows.pop_front();
            bad  = (m_tdata[7:0] !== want.row_index)
                || (m_tdata[8] !== want.assigned)
                || (m_tdata[14:9] !== want.assigned_column)
                || (m_tdata[62:15] !== want.total_cost)
                || (m_tdata[63] !== 1'b0)
                || (m_tlast !== want.last);
            if (bad)
            begin
                if (mismatches < 10)
                    $display({"%t: row mismatch: exp row=%0d asg=%b col=%0d total=%0d last=%b",
                              " | got row=%0d asg=%b col=%0d total=%0d pad=%b last=%b"},
                             $realtime, want.row_index, want.assigned, want.assigned_column,
                             want.total_cost, want.last, m_tdata[7:0], m_tdata[8],
                             m_tdata[14:9], $signed(m_tdata[62:15]), m_tdata[63], m_tlast);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            claimed     = '0;
            row_count   = '0;
            running_sum = '0;
            gate        = 32'sh7FFF_FFFF;
            clear_row_pick();
            expected_rows.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                gate = cfg_data;
            if (s_tvalid && s_tready)
                predict_row_pick(s_tdata[COST_W-1:0], s_tlast, s_tuser);
            if (m_tvalid && m_tready)
                check_row_beat();
        end
        rows_pending <= expected_rows.size();
        fail_count   <= mismatches;
    end

endmodule

// ===== test/tb_greedy_gated_assignment.sv =====
// Testbench top for the greedy gated assignment block: clock, reset, cost stimulus,
// gate writes and the verdict. Depends on gga_pkg, the block and gga_assignment_checker.
`timescale 1ns / 1ps

module tb_greedy_gated_assignment;
    import gga_pkg::*;

    localparam logic signed [COST_W-1:0] COST_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COST_W-1:0] COST_MIN = 32'sh8000_0000;
    localparam int RANDOM_ITEMS = 560;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [COST_W-1:0]      cfg_data  = '0;

    int fail_count;
    int rows_pending;

    // no idling on either side while set
    bit steady = 1'b0;
    logic signed [COST_W-1:0] gate_now = COST_MAX;

    greedy_gated_assignment dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    gga_assignment_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .rows_pending (rows_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: random stalls outside the steady stretch
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            m_tready <= steady || ($urandom_range(99) >= 34);
        end
    end

    // One cost beat, with random idle cycles ahead of it
    task automatic send_cost(input logic signed [COST_W-1:0] cost,
                             input logic row_end, input logic matrix_end);
        while (!steady && $urandom_range(99) < 34)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cost;
        s_tlast  <= row_end;
        s_tuser  <= matrix_end;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Hold the sender until every queued row has come out and the pipe is empty
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (rows_pending != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_gate(input logic signed [COST_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        gate_now = value;
    endtask

    function automatic logic signed [COST_W-1:0] pick_gate();
        case ($urandom_range(5))
            0:       return COST_MAX;
            1:       return COST_MIN;
            2:       return '0;
            3:       return $urandom();
            default: return $urandom_range(4000) - 2000;
        endcase
    endfunction

    // Cost mix: full range, small values with many ties, extremes, and values at the gate
    function automatic logic signed [COST_W-1:0] pick_cost();
        int          sel;
        longint      near;
        sel = $urandom_range(99);
        if (sel < 35)
            return $urandom();
        if (sel < 70)
            return $urandom_range(2000) - 1000;
        if (sel < 80)
        begin
            case ($urandom_range(4))
                0:       return COST_MAX;
                1:       return COST_MIN;
                2:       return '0;
                3:       return -1;
                default: return 1;
            endcase
        end
        near = longint'(gate_now) + $urandom_range(20) - 10;
        if (near > longint'(COST_MAX))
            near = COST_MAX;
        if (near < longint'(COST_MIN))
            near = COST_MIN;
        return near[COST_W-1:0];
    endfunction

    initial
    begin
        int  sent;
        int  rows;
        int  len;
        bit  noise;
        bit  broken;
        bit  wrap_done;
        bit  long_done;
        bit  row_done;
        bit  at_end;
        logic rend;
        logic mend;

        sent      = 0;
        wrap_done = 1'b0;
        long_done = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: ties go to the first column, extremes, gate at its reset value
        send_cost(COST_MAX, 1'b0, 1'b0);
        send_cost(COST_MIN, 1'b0, 1'b0);
        send_cost(COST_MIN, 1'b0, 1'b0);
        send_cost('0, 1'b1, 1'b0);
        // column claimed by the previous row is skipped
        send_cost(5, 1'b0, 1'b0);
        send_cost(COST_MIN, 1'b0, 1'b0);
        send_cost(5, 1'b1, 1'b0);
        // matrix end without row end, nothing left to claim
        send_cost(3, 1'b0, 1'b0);
        send_cost(3, 1'b0, 1'b1);
        // one-entry matrix exactly at the gate
        send_cost(COST_MAX, 1'b1, 1'b1);
        // lowest gate: only the most negative cost passes
        set_gate(COST_MIN);
        send_cost(COST_MIN + 1, 1'b0, 1'b0);
        send_cost(COST_MIN, 1'b0, 1'b0);
        send_cost('0, 1'b1, 1'b1);
        // gate lowered mid-row keeps the cost already taken
        set_gate(COST_MAX);
        send_cost(100, 1'b0, 1'b0);
        set_gate(50);
        send_cost(80, 1'b0, 1'b0);
        send_cost(200, 1'b1, 1'b1);
        // zero gate with a tie of negative costs
        set_gate('0);
        send_cost(-1, 1'b0, 1'b0);
        send_cost(-1, 1'b0, 1'b0);
        send_cost(1, 1'b1, 1'b1);

        // Random matrices
        while (sent < RANDOM_ITEMS)
        begin
            // one matrix with more rows than the row counter holds, single-column rows
            if (!wrap_done && sent >= 200)
            begin
                wrap_done = 1'b1;
                set_gate(pick_gate());
                steady = 1'b1;
                for (int r = 0; r < MAX_ROWS + 4; r++)
                begin
                    send_cost(pick_cost(), 1'b1, r == MAX_ROWS + 3);
                    sent++;
                end
                steady = 1'b0;
            end

            if ($urandom_range(3) == 0)
                set_gate(pick_gate());
            rows   = $urandom_range(1, 6);
            noise  = ($urandom_range(9) == 0);
            broken = ($urandom_range(4) == 0);
            for (int r = 0; r < rows; r++)
            begin
                // long rows run past the column capacity and the counter's top
                if (!long_done || $urandom_range(11) == 0)
                    len = $urandom_range(130, 140);
                else
                    len = $urandom_range(1, 10);
                long_done = 1'b1;
                for (int k = 0; k < len; k++)
                begin
                    row_done = (k == len - 1);
                    at_end   = row_done && (r == rows - 1);
                    if (noise)
                    begin
                        rend = ($urandom_range(3) == 0);
                        mend = ($urandom_range(15) == 0);
                    end
                    else
                    begin
                        rend = row_done && !(at_end && broken);
                        mend = at_end;
                    end
                    if ($urandom_range(199) == 0)
                        set_gate(pick_gate());
                    send_cost(pick_cost(), rend, mend);
                    sent++;
                end
            end
        end

        drain_results();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/gga_pkg.sv
rtl/gga_core.sv
rtl/gga_out_buf.sv
rtl/greedy_gated_assignment.sv
test/gga_assignment_checker.sv
test/tb_greedy_gated_assignment.sv
